[rtl/core/ihc_pkg.sv]
`default_nettype none

package ihc_pkg;

  // verdict codes, in priority order after accept
  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_TTL_ZERO  = 3'd1,
    VERDICT_BAD_VER   = 3'd2,
    VERDICT_BAD_IHL   = 3'd3,
    VERDICT_WRONG_DST = 3'd4,
    VERDICT_BAD_CSUM  = 3'd5
  } verdict_e;

  // one header-state step as seen by the output stage
  typedef struct packed {
    logic     fire;
    verdict_e verdict;
  } step_t;

  localparam int unsigned WordW    = 16;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned OutDataW = 8;

  localparam logic [AddrW-1:0] HostAddrReset = '0;

endpackage

`default_nettype wire

[rtl/core/ihc_hdr_state.sv]
`default_nettype none

module ihc_hdr_state (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       go_i,
  input  wire logic [ihc_pkg::WordW-1:0]  word_i,
  input  wire logic                       first_i,
  input  wire logic [ihc_pkg::AddrW-1:0]  host_i,
  output      ihc_pkg::step_t             step_o
);
  import ihc_pkg::*;

  localparam logic [4:0] PosVersion  = 5'd0;
  localparam logic [4:0] PosTtl      = 5'd4;
  localparam logic [4:0] PosDstHi    = 5'd8;
  localparam logic [4:0] PosDstLo    = 5'd9;
  localparam logic [4:0] MinEndPos   = 5'd9;
  localparam logic [4:0] MinHdrWords = 5'd10;
  localparam logic [3:0] Ipv4Ver     = 4'd4;
  localparam logic [3:0] MaxBadIhl   = 4'd4;

  logic [4:0]       pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic [3:0]       ver_q, ver_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [7:0]       ttl_q, ttl_d;
  logic [AddrW-1:0] dst_q, dst_d;
  logic             given_q, given_d;

  logic [4:0]  pos_c;
  logic [15:0] sum_c;
  logic [3:0]  ver_c, ihl_c;
  logic [7:0]  ttl_c;
  logic [AddrW-1:0] dst_c;
  logic [4:0]  hw2;
  logic [16:0] sum_wide;
  logic [4:0]  end_pos;
  logic        active, done;
  verdict_e    verdict;

  // header field capture, checksum fold and verdict for one word
  always_comb begin
    pos_c = first_i ? '0 : pos_q;
    sum_c = first_i ? '0 : sum_q;
    ver_c = first_i ? '0 : ver_q;
    ihl_c = first_i ? '0 : ihl_q;
    ttl_c = first_i ? '0 : ttl_q;
    dst_c = first_i ? '0 : dst_q;
    if (pos_c == PosVersion) begin
      ver_c = word_i[15:12];
      ihl_c = word_i[11:8];
    end
    hw2 = {ihl_c, 1'b0};
    sum_wide = {1'b0, sum_c} + {1'b0, word_i};
    if (pos_c < hw2) begin
      sum_c = sum_wide[15:0] + {15'd0, sum_wide[16]};
    end
    if (pos_c == PosTtl) ttl_c = word_i[15:8];
    if (pos_c == PosDstHi) dst_c[31:16] = word_i;
    if (pos_c == PosDstLo) dst_c[15:0] = word_i;
    end_pos = (hw2 > MinHdrWords) ? hw2 - 5'd1 : MinEndPos;
    done    = (pos_c == end_pos);
    active  = go_i && (first_i || !given_q);

    if (ttl_c == '0) verdict = VERDICT_TTL_ZERO;
    else if (ver_c != Ipv4Ver) verdict = VERDICT_BAD_VER;
    else if (ihl_c <= MaxBadIhl) verdict = VERDICT_BAD_IHL;
    else if (dst_c != host_i) verdict = VERDICT_WRONG_DST;
    else if (sum_c != 16'hffff) verdict = VERDICT_BAD_CSUM;
    else verdict = VERDICT_ACCEPT;

    pos_d   = pos_q;
    sum_d   = sum_q;
    ver_d   = ver_q;
    ihl_d   = ihl_q;
    ttl_d   = ttl_q;
    dst_d   = dst_q;
    given_d = given_q;
    if (active) begin
      sum_d = sum_c;
      ver_d = ver_c;
      ihl_d = ihl_c;
      ttl_d = ttl_c;
      dst_d = dst_c;
      if (done) begin
        pos_d   = pos_c;
        given_d = 1'b1;
      end else begin
        pos_d   = pos_c + 5'd1;
        given_d = 1'b0;
      end
    end
    step_o.fire    = active && done;
    step_o.verdict = verdict;
  end

  // header state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      ver_q   <= '0;
      ihl_q   <= '0;
      ttl_q   <= '0;
      dst_q   <= '0;
      given_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      ver_q   <= ver_d;
      ihl_q   <= ihl_d;
      ttl_q   <= ttl_d;
      dst_q   <= dst_d;
      given_q <= given_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a verdict closes the header
  a_fire_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_o.fire |=> given_q)
    else $error("verdict did not close header");

  // an open header word advances the position by one
  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && !first_i && !given_q && !done |=> pos_q == $past(pos_q) + 5'd1)
    else $error("word position did not advance");

  // a word outside any packet leaves the state untouched
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && !first_i && given_q |=> given_q && $stable(pos_q))
    else $error("stray word changed header state");
`endif

endmodule

`default_nettype wire

[rtl/core/ipv4_header_check_unit.sv]
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata packet_word, tuser first_word
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata verdict
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_data_i host_address
//
// one packet word per cycle while m_axis is not stalled; each word waits in the input register,
// then the header update and verdict form in one pass into the result register
// a verdict is valid once the word ending the header has left the input register
// reset clears all header state and leaves the block waiting for a first word
// a stall on m_axis holds the result and the input register; the input side
// keeps taking words until both registers are full
`default_nettype none

module ipv4_header_check_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [ihc_pkg::WordW-1:0]     s_axis_tdata,  // [15:0] packet_word
  input  wire logic                          s_axis_tuser,  // [0] first_word
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [ihc_pkg::OutDataW-1:0]  m_axis_tdata,  // [2:0] verdict, rest zero
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [ihc_pkg::AddrW-1:0]     cfg_data_i
);
  import ihc_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [WordW-1:0] in_word_q;
  logic             in_first_q;
  logic             out_valid_q, out_valid_d;
  verdict_e         out_verdict_q;
  logic [AddrW-1:0] host_q;
  logic             advance, go;
  step_t            step;

  // pipeline moves when the result register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign go            = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  ihc_hdr_state u_hdr_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .word_i  (in_word_q),
    .first_i (in_first_q),
    .host_i  (host_q),
    .step_o  (step)
  );

  // input and result stage control
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) in_valid_d = s_axis_tvalid;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = go && step.fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      host_q      <= HostAddrReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) host_q <= cfg_data_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
    if (advance && go && step.fire) out_verdict_q <= step.verdict;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 3){1'b0}}, out_verdict_q};

`ifndef NO_ASSERTIONS
  // a result only comes from a word held in the input register
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without input transaction");

  // input side stalls only when both registers are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled with room available");

  // host address follows the configuration transaction
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> host_q == $past(cfg_data_i))
    else $error("host address not written");
`endif

endmodule

`default_nettype wire
